FILE: rtl/elastic_disc_collision_pair_defines.svh
// Assertion macros used by the top level of the disc collision block.
`ifndef ELASTIC_DISC_COLLISION_PAIR_DEFINES_SVH
`define ELASTIC_DISC_COLLISION_PAIR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDCP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("edcp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EDCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("edcp assertion failed");

`endif

FILE: rtl/edcp_pkg.sv
package edcp_pkg;

    localparam int FRAC_BITS = 12;
    localparam int VW = 24;
    localparam int RW = 22;
    localparam int DW = VW + 1;
    localparam int SW = 2 * DW + 1;
    localparam int MW = 2 * VW + 1;
    localparam int QW = DW;
    localparam int NW = MW + DW + 1;
    localparam int EW = QW + 2;
    localparam logic [RW-1:0] RADIUS_RESET = RW'(10 << FRAC_BITS);

    typedef struct packed {
        logic signed [VW-1:0] v1x;
        logic signed [VW-1:0] v1y;
        logic signed [VW-1:0] v2x;
        logic signed [VW-1:0] v2y;
        logic                 hit;
    } carry_t;

    typedef struct packed {
        logic [SW-1:0] remx;
        logic [SW-1:0] remy;
        logic [QW-1:0] numx;
        logic [QW-1:0] numy;
        logic [SW-1:0] den;
        logic          sx;
        logic          sy;
        carry_t        cr;
    } div_t;

endpackage

FILE: rtl/edcp_if.sv
interface edcp_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [23:0]   first_pos_x;
    logic signed [23:0]   first_pos_y;
    logic signed [23:0]   first_vel_x;
    logic signed [23:0]   first_vel_y;
    logic signed [23:0]   second_pos_x;
    logic signed [23:0]   second_pos_y;
    logic signed [23:0]   second_vel_x;
    logic signed [23:0]   second_vel_y;
    modport source (output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
                    second_pos_x, second_pos_y, second_vel_x, second_vel_y, input ready);
    modport sink (input valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
                  second_pos_x, second_pos_y, second_vel_x, second_vel_y, output ready);
endinterface

interface edcp_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [23:0]   new_first_vel_x;
    logic signed [23:0]   new_first_vel_y;
    logic signed [23:0]   new_second_vel_x;
    logic signed [23:0]   new_second_vel_y;
    logic                 collided;
    logic                 saturated;
    modport source (output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
                    new_second_vel_y, collided, saturated, input ready);
    modport sink (input valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
                  new_second_vel_y, collided, saturated, output ready);
endinterface

interface edcp_cfg_if;
    logic          valid;
    logic          ready;
    logic [21:0]   particle_radius;
    modport source (output valid, particle_radius, input ready);
    modport sink (input valid, particle_radius, output ready);
endinterface

FILE: rtl/edcp_front.sv
module edcp_front
    import edcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [RW-1:0] radius,
    edcp_in_if.sink       pair_in,
    output logic          front_valid,
    output div_t          front_data
);

    logic [4:0] valid_reg;
    logic [4:0] valid_next;

    carry_t               c1_reg, c2_reg, c3_reg, c4_reg;
    logic signed [DW-1:0] dpx_reg, dpy_reg, dvx_reg, dvy_reg;
    logic signed [DW-1:0] dpx2_reg, dpy2_reg;
    logic signed [2*DW-1:0] ppx_reg, ppy_reg, pdx_reg, pdy_reg;
    logic [2*RW+1:0]      dd_reg;
    logic [SW-1:0]        den3_reg, den4_reg;
    logic [MW-1:0]        mdot_reg;
    logic [DW-1:0]        mcx_reg, mcy_reg;
    logic                 sx3_reg, sy3_reg, sx4_reg, sy4_reg;
    logic [2*DW-1:0]      plx_reg, ply_reg;
    logic [2*DW-2:0]      phx_reg, phy_reg;
    div_t                 d5_reg;

    logic [RW:0]          diam;
    logic [SW-1:0]        dist2;
    logic signed [SW-1:0] dot;
    logic signed [SW-1:0] abs_dot;
    logic signed [DW-1:0] abs_x, abs_y;
    logic [NW-1:0]        nx, ny;

    assign valid_next = {valid_reg[3:0], pair_in.valid};
    assign pair_in.ready = en;
    assign diam = {radius, 1'b0};
    assign dist2 = SW'(ppx_reg) + SW'(ppy_reg);
    assign dot = SW'(pdx_reg) + SW'(pdy_reg);
    assign abs_dot = dot[SW-1] ? -dot : dot;
    assign abs_x = dpx2_reg[DW-1] ? -dpx2_reg : dpx2_reg;
    assign abs_y = dpy2_reg[DW-1] ? -dpy2_reg : dpy2_reg;
    assign nx = NW'({phx_reg, {DW{1'b0}}}) + NW'(plx_reg);
    assign ny = NW'({phy_reg, {DW{1'b0}}}) + NW'(ply_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dpx_reg <= DW'(pair_in.first_pos_x) - DW'(pair_in.second_pos_x);
            dpy_reg <= DW'(pair_in.first_pos_y) - DW'(pair_in.second_pos_y);
            dvx_reg <= DW'(pair_in.first_vel_x) - DW'(pair_in.second_vel_x);
            dvy_reg <= DW'(pair_in.first_vel_y) - DW'(pair_in.second_vel_y);
            c1_reg.v1x <= pair_in.first_vel_x;
            c1_reg.v1y <= pair_in.first_vel_y;
            c1_reg.v2x <= pair_in.second_vel_x;
            c1_reg.v2y <= pair_in.second_vel_y;
            c1_reg.hit <= 1'b0;

            ppx_reg  <= dpx_reg * dpx_reg;
            ppy_reg  <= dpy_reg * dpy_reg;
            pdx_reg  <= dvx_reg * dpx_reg;
            pdy_reg  <= dvy_reg * dpy_reg;
            dd_reg   <= (2*RW+2)'(diam) * (2*RW+2)'(diam);
            dpx2_reg <= dpx_reg;
            dpy2_reg <= dpy_reg;
            c2_reg   <= c1_reg;

            den3_reg   <= dist2;
            mdot_reg   <= abs_dot[MW-1:0];
            mcx_reg    <= abs_x;
            mcy_reg    <= abs_y;
            sx3_reg    <= dpx2_reg[DW-1];
            sy3_reg    <= dpy2_reg[DW-1];
            c3_reg     <= {c2_reg.v1x, c2_reg.v1y, c2_reg.v2x, c2_reg.v2y,
                           (dist2 < SW'(dd_reg)) && dot[SW-1]};

            plx_reg  <= (2*DW)'(mdot_reg[DW-1:0]) * (2*DW)'(mcx_reg);
            ply_reg  <= (2*DW)'(mdot_reg[DW-1:0]) * (2*DW)'(mcy_reg);
            phx_reg  <= (2*DW-1)'(mdot_reg[MW-1:DW]) * (2*DW-1)'(mcx_reg);
            phy_reg  <= (2*DW-1)'(mdot_reg[MW-1:DW]) * (2*DW-1)'(mcy_reg);
            den4_reg <= den3_reg;
            sx4_reg  <= sx3_reg;
            sy4_reg  <= sy3_reg;
            c4_reg   <= c3_reg;

            d5_reg.remx <= SW'(nx[NW-1:QW]);
            d5_reg.remy <= SW'(ny[NW-1:QW]);
            d5_reg.numx <= nx[QW-1:0];
            d5_reg.numy <= ny[QW-1:0];
            d5_reg.den  <= den4_reg;
            d5_reg.sx   <= sx4_reg;
            d5_reg.sy   <= sy4_reg;
            d5_reg.cr   <= c4_reg;
        end
    end

    assign front_valid = valid_reg[4];
    assign front_data  = d5_reg;

endmodule

FILE: rtl/edcp_div.sv
module edcp_div
    import edcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic [QW-1:0] valid_reg;
    logic [QW-1:0] valid_next;
    div_t          stage_reg [QW];

    // One quotient bit per stage for both components.
    function automatic div_t div_step(div_t d);
        div_t     r;
        logic [SW:0] tx;
        logic [SW:0] ty;
        logic     qx;
        logic     qy;
        r  = d;
        tx = {d.remx, d.numx[QW-1]};
        ty = {d.remy, d.numy[QW-1]};
        qx = (tx >= {1'b0, d.den});
        qy = (ty >= {1'b0, d.den});
        if (qx)
        begin
            tx = tx - {1'b0, d.den};
        end
        if (qy)
        begin
            ty = ty - {1'b0, d.den};
        end
        r.remx = tx[SW-1:0];
        r.remy = ty[SW-1:0];
        r.numx = {d.numx[QW-2:0], qx};
        r.numy = {d.numy[QW-2:0], qy};
        return r;
    endfunction

    assign valid_next = {valid_reg[QW-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= div_step(in_data);
            for (int i = 1; i < QW; i++)
            begin
                stage_reg[i] <= div_step(stage_reg[i-1]);
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_data  = stage_reg[QW-1];

endmodule

FILE: rtl/edcp_back.sv
module edcp_back
    import edcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  div_t      in_data,
    edcp_out_if.source pair_out
);

    logic                 out_valid_reg;
    logic [VW-1:0]        n1x_reg, n1y_reg, n2x_reg, n2y_reg;
    logic                 hit_reg, sat_reg;

    logic                 rux, ruy;
    logic [EW-1:0]        qrx, qry;
    logic signed [EW-1:0] ex, ey;
    logic [VW:0]          c1x, c1y, c2x, c2y;

    function automatic logic [VW:0] clamp_sum(logic signed [EW-1:0] v);
        logic [VW:0] r;
        if (v > EW'(2**(VW-1) - 1))
        begin
            r = {1'b1, 1'b0, {(VW-1){1'b1}}};
        end
        else if (v < -EW'(2**(VW-1)))
        begin
            r = {1'b1, 1'b1, {(VW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, v[VW-1:0]};
        end
        return r;
    endfunction

    // Round half away from zero on the magnitude, then apply the sign.
    assign rux = {in_data.remx, 1'b0} >= {1'b0, in_data.den};
    assign ruy = {in_data.remy, 1'b0} >= {1'b0, in_data.den};
    assign qrx = EW'(in_data.numx) + EW'(rux);
    assign qry = EW'(in_data.numy) + EW'(ruy);
    assign ex = in_data.sx ? signed'(qrx) : -signed'(qrx);
    assign ey = in_data.sy ? signed'(qry) : -signed'(qry);
    assign c1x = clamp_sum(EW'(in_data.cr.v1x) - ex);
    assign c1y = clamp_sum(EW'(in_data.cr.v1y) - ey);
    assign c2x = clamp_sum(EW'(in_data.cr.v2x) + ex);
    assign c2y = clamp_sum(EW'(in_data.cr.v2y) + ey);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= in_data.cr.hit;
            if (in_data.cr.hit)
            begin
                n1x_reg <= c1x[VW-1:0];
                n1y_reg <= c1y[VW-1:0];
                n2x_reg <= c2x[VW-1:0];
                n2y_reg <= c2y[VW-1:0];
                sat_reg <= c1x[VW] | c1y[VW] | c2x[VW] | c2y[VW];
            end
            else
            begin
                n1x_reg <= in_data.cr.v1x;
                n1y_reg <= in_data.cr.v1y;
                n2x_reg <= in_data.cr.v2x;
                n2y_reg <= in_data.cr.v2y;
                sat_reg <= 1'b0;
            end
        end
    end

    assign pair_out.valid            = out_valid_reg;
    assign pair_out.new_first_vel_x  = n1x_reg;
    assign pair_out.new_first_vel_y  = n1y_reg;
    assign pair_out.new_second_vel_x = n2x_reg;
    assign pair_out.new_second_vel_y = n2y_reg;
    assign pair_out.collided         = hit_reg;
    assign pair_out.saturated        = sat_reg;

endmodule

FILE: rtl/elastic_disc_collision_pair.sv
// Channel    Direction  Contents
// pair_in    in         positions and velocities of two discs, one pair per beat
// pair_out   out        new velocities, collided and saturated flags, one per beat
// cfg        in         particle_radius write, always ready
//
// One pair enters per cycle while the output beat is not stalled.
// The path holds 31 register stages: five front, 25 quotient-bit and one output stage.
// Reset clears all valid bits and sets the radius to ten units.
// A stalled output beat holds the whole pipeline, and pair_in.ready drops with it.
`include "elastic_disc_collision_pair_defines.svh"

module elastic_disc_collision_pair
    import edcp_pkg::*;
#(
    parameter int FRAC_BITS = edcp_pkg::FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    edcp_in_if.sink    pair_in,
    edcp_out_if.source pair_out,
    edcp_cfg_if.sink   cfg
);

    logic [RW-1:0] radius_reg;
    logic          pipe_en;
    logic          front_valid;
    div_t          front_data;
    logic          div_valid;
    div_t          div_data;
    logic          cfg_fire;
    logic          plain_beat;

    assign pipe_en    = !pair_out.valid || pair_out.ready;
    assign cfg.ready  = 1'b1;
    assign cfg_fire   = cfg.valid && cfg.ready;
    assign plain_beat = pair_out.valid && !pair_out.collided;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RW'(10 << FRAC_BITS);
        end
        else if (cfg.valid)
        begin
            radius_reg <= cfg.particle_radius;
        end
    end

    edcp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_en),
        .radius      (radius_reg),
        .pair_in     (pair_in),
        .front_valid (front_valid),
        .front_data  (front_data)
    );

    edcp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    edcp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (div_valid),
        .in_data  (div_data),
        .pair_out (pair_out)
    );

    `EDCP_ASSERT_IMPL(a_nohit_nosat, clk, rst_n, plain_beat, !pair_out.saturated)
    `EDCP_ASSERT_NEXT(a_stall_front, clk, rst_n, !pipe_en, $stable(front_valid))
    `EDCP_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_fire, radius_reg == $past(cfg.particle_radius))

endmodule

FILE: tb/sv/elastic_disc_collision_pair_checker.sv
`timescale 1ns / 1ps

module elastic_disc_collision_pair_checker
    import edcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    edcp_in_if          pair_in,
    edcp_out_if         pair_out,
    edcp_cfg_if         cfg,
    output int          fail_count,
    output int          pending_count,
    output int          result_count,
    output int          hit_count,
    output int          clip_count
);

    typedef struct packed {
        logic signed [VW-1:0] n1x;
        logic signed [VW-1:0] n1y;
        logic signed [VW-1:0] n2x;
        logic signed [VW-1:0] n2y;
        logic                 hit;
        logic                 sat;
    } velocities_t;

    velocities_t expected_velocities[$];
    logic [RW-1:0] radius;

    function automatic longint round_share(longint dot, longint c, longint den);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        longint md;
        longint mc;
        md = dot < 0 ? -dot : dot;
        mc = c < 0 ? -c : c;
        num = 128'(md) * 128'(mc);
        q = num / 128'(den);
        r = num % 128'(den);
        if (r >= 128'(den) - r)
            q = q + 1;
        return ((dot < 0) != (c < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [VW-1:0] clip(longint v, inout logic sat);
        if (v > 8388607)
        begin
            sat = 1'b1;
            return 24'sh7fffff;
        end
        if (v < -8388608)
        begin
            sat = 1'b1;
            return 24'sh800000;
        end
        return v[VW-1:0];
    endfunction

    function automatic velocities_t collide_pair();
        velocities_t e;
        longint dpx, dpy, dvx, dvy, dist2, diam, dot, ex, ey;
        longint n1x, n1y, n2x, n2y;
        logic sat;
        dpx = longint'(pair_in.first_pos_x) - longint'(pair_in.second_pos_x);
        dpy = longint'(pair_in.first_pos_y) - longint'(pair_in.second_pos_y);
        dvx = longint'(pair_in.first_vel_x) - longint'(pair_in.second_vel_x);
        dvy = longint'(pair_in.first_vel_y) - longint'(pair_in.second_vel_y);
        dist2 = dpx * dpx + dpy * dpy;
        diam = 2 * longint'(radius);
        dot = dvx * dpx + dvy * dpy;
        n1x = pair_in.first_vel_x;
        n1y = pair_in.first_vel_y;
        n2x = pair_in.second_vel_x;
        n2y = pair_in.second_vel_y;
        e.hit = (dist2 < diam * diam) && (dot < 0);
        if (e.hit)
        begin
            ex = round_share(dot, dpx, dist2);
            ey = round_share(dot, dpy, dist2);
            n1x -= ex;
            n1y -= ey;
            n2x += ex;
            n2y += ey;
        end
        sat = 1'b0;
        e.n1x = clip(n1x, sat);
        e.n1y = clip(n1y, sat);
        e.n2x = clip(n2x, sat);
        e.n2y = clip(n2y, sat);
        e.sat = sat;
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        velocities_t got;
        velocities_t e;
        if (!rst_n)
        begin
            radius <= RADIUS_RESET;
            fail_count <= 0;
            pending_count <= 0;
            result_count <= 0;
            hit_count <= 0;
            clip_count <= 0;
            expected_velocities.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                radius <= cfg.particle_radius;
            if (pair_in.valid && pair_in.ready)
                expected_velocities.insert(expected_velocities.size(), collide_pair());
            if (pair_out.valid && pair_out.ready)
            begin
                got = {pair_out.new_first_vel_x, pair_out.new_first_vel_y,
                       pair_out.new_second_vel_x, pair_out.new_second_vel_y,
                       pair_out.collided, pair_out.saturated};
                result_count <= result_count + 1;
                if (expected_velocities.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result beat: %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_velocities.pop_front();
                    hit_count <= hit_count + e.hit;
                    clip_count <= clip_count + e.sat;
                    if (got !== e)
                    begin
                        if (fail_count < 10)
                            $display("Mismatch: expected %p, actual %p", e, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_velocities.size();
        end
    end

endmodule

FILE: tb/sv/elastic_disc_collision_pair_tb.sv
`timescale 1ns / 1ps

module elastic_disc_collision_pair_tb;
    import edcp_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int fail_count, pending_count, result_count, hit_count, clip_count;
    int send_idle = 0;
    int sink_stall = 0;
    bit hold_off = 1'b0;

    edcp_in_if pair_in ();
    edcp_out_if pair_out ();
    edcp_cfg_if cfg ();

    elastic_disc_collision_pair dut (
        .clk(clk), .rst_n(rst_n), .pair_in(pair_in), .pair_out(pair_out), .cfg(cfg));

    elastic_disc_collision_pair_checker checker_i (
        .clk(clk), .rst_n(rst_n), .pair_in(pair_in), .pair_out(pair_out), .cfg(cfg),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count), .hit_count(hit_count), .clip_count(clip_count));

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        pair_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.particle_radius = '0;
        pair_in.valid = 1'b0;
        {pair_in.first_pos_x, pair_in.first_pos_y, pair_in.first_vel_x,
         pair_in.first_vel_y, pair_in.second_pos_x, pair_in.second_pos_y,
         pair_in.second_vel_x, pair_in.second_vel_y} = '0;
    end

    always @(posedge clk)
    begin
        if (hold_off)
            pair_out.ready <= 1'b0;
        else
            pair_out.ready <= ($urandom_range(99) >= sink_stall);
    end

    task automatic send_pair(input logic signed [23:0] p1x, p1y, v1x, v1y,
                             p2x, p2y, v2x, v2y);
        while ($urandom_range(99) < send_idle)
        begin
            pair_in.valid <= 1'b0;
            @(posedge clk);
        end
        pair_in.valid <= 1'b1;
        {pair_in.first_pos_x, pair_in.first_pos_y, pair_in.first_vel_x,
         pair_in.first_vel_y, pair_in.second_pos_x, pair_in.second_pos_y,
         pair_in.second_vel_x, pair_in.second_vel_y}
            <= {p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y};
        do
            @(posedge clk);
        while (!pair_in.ready);
    endtask

    task automatic send_ints(input int p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y);
        send_pair(24'(p1x), 24'(p1y), 24'(v1x), 24'(v1y),
                  24'(p2x), 24'(p2y), 24'(v2x), 24'(v2y));
    endtask

    task automatic drain();
        pair_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_radius(input logic [21:0] r);
        cfg.valid <= 1'b1;
        cfg.particle_radius <= r;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [23:0] any_value();
        return 24'($urandom);
    endfunction

    function automatic logic signed [23:0] near(input logic signed [23:0] c, int span);
        longint v;
        v = longint'(c) + $urandom_range(2 * span) - span;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[23:0];
    endfunction

    task automatic random_pairs(input int count, input int span);
        logic signed [23:0] p1x, p1y, v1x, v1y;
        int vspan;
        repeat (count)
        begin
            p1x = any_value();
            p1y = any_value();
            v1x = any_value();
            v1y = any_value();
            vspan = ($urandom_range(3) == 0) ? 8388607 : $urandom_range(1, 200000);
            if ($urandom_range(9) == 0)
                send_pair(p1x, p1y, v1x, v1y, any_value(), any_value(),
                          any_value(), any_value());
            else
                send_pair(p1x, p1y, v1x, v1y, near(p1x, span), near(p1y, span),
                          near(v1x, vspan), near(v1y, vspan));
        end
    endtask

    localparam int MAXV = 8388607;
    localparam int MINV = -8388608;

    initial
    begin
        int span;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ints(0, 0, 4096, 0, 0, 0, -4096, 0);
        send_ints(4096, 0, -4096, 0, -4096, 0, 4096, 0);
        send_ints(4096, 0, 4096, 0, -4096, 0, -4096, 0);
        send_ints(4096, 4096, -8192, 0, 0, 0, 0, 0);
        send_ints(MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MAXV);
        send_ints(1000, 0, MINV, MAXV, 0, 0, MAXV, MINV);
        send_ints(30000, 20000, -1, -1, 0, 0, 1, 1);
        send_ints(81919, 0, -100, 0, 0, 0, 0, 0);
        send_ints(81920, 0, -100, 0, 0, 0, 0, 0);
        send_ints(3, 1, -5, 7, 0, 0, 2, -3);
        send_ints(-1, -1, 1, 1, 0, 0, 0, 0);
        send_ints(MINV, 0, MAXV, 0, MINV + 1, 0, MINV, 0);
        drain();

        write_radius('0);
        send_ints(0, 1, 0, -100, 0, 0, 0, 100);
        send_ints(5, 5, -1, -1, 5, 5, 1, 1);
        drain();
        write_radius(22'h3fffff);
        send_ints(MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MAXV);
        send_ints(MINV, 0, MINV, 0, MAXV, 0, MAXV, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle = (phase == 1 || phase == 3) ? ((phase == 1) ? 75 : 7) : 0;
            sink_stall = (phase == 2) ? 75 : ((phase == 3) ? 7 : 0);
            drain();
            case (phase)
                0: write_radius(22'd40960);
                1: write_radius(22'h3fffff);
                2: write_radius(22'($urandom_range(1, 4095)));
                default: write_radius(22'($urandom_range(22'h3fffff)));
            endcase
            span = (phase == 1) ? 8388607 : 300000;
            random_pairs(400, span);
        end

        send_idle = 0;
        sink_stall = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            random_pairs(120, 200000);
        join
        drain();
        write_radius(22'd40960);
        random_pairs(30, 100000);
        drain();

        $display("Covered %0d result beats, %0d collisions, %0d clipped, under",
                 result_count, hit_count, clip_count);
        $display("radius settings from zero to full scale and four idling mixes.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: elastic_disc_collision_pair.f
+incdir+rtl
rtl/edcp_pkg.sv
rtl/edcp_if.sv
rtl/edcp_front.sv
rtl/edcp_div.sv
rtl/edcp_back.sv
rtl/elastic_disc_collision_pair.sv
tb/sv/elastic_disc_collision_pair_checker.sv
tb/sv/elastic_disc_collision_pair_tb.sv
